>>> rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WAV stream decoder package
// Types, codes and constants shared by the WAV stream decoder modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK_HDR,
        PH_BODY,
        PH_PAD,
        PH_HALT,
        PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_NO_DATA    = 3'd3,
        ST_BAD_CHAN   = 3'd4,
        ST_BAD_FORMAT = 3'd5,
        ST_BAD_DEPTH  = 3'd6,
        ST_NO_FMT     = 3'd7
    } t_status;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    // Magic words and chunk ids, first file byte in the low byte.
    localparam logic [31:0] RIFF_MAGIC = 32'h4646_4952;
    localparam logic [31:0] WAVE_MAGIC = 32'h4556_4157;
    localparam logic [31:0] ID_FMT     = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA    = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM       = 16'h0001;
    localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
    localparam logic [7:0]  PCM8_BIAS     = 8'd128;
    localparam logic [3:0]  HEADER_LEN    = 4'd12;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } t_in_word;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] sample;
        logic               channel_index;
        logic [1:0]         channel_count;
        logic [31:0]        sample_rate;
        logic [15:0]        bit_depth;
        t_status            status;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [1:0] count;
        t_out_word  first;
        t_out_word  second;
    } t_push;

endpackage

>>> rtl/core/wsd_if.sv
// ----------------------------------------------------------------------------
// WAV stream decoder channels
// Valid/ready channels for input bytes and for decoded result words.
// ----------------------------------------------------------------------------
interface wsd_in_if import wsd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wsd_out_if import wsd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/wsd_parser.sv
// ----------------------------------------------------------------------------
// WAV stream decoder parser
// Per-byte RIFF/WAVE parse step: header check, chunk walk, fmt capture,
// validation and sample assembly, producing up to two result words.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; #(
    parameter int MAX_CHANNELS = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_word i_word,
    output t_push    o_push
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_chunk_id, n_chunk_id;
    logic [31:0] r_chunk_size, n_chunk_size;
    logic [31:0] r_body_rem, n_body_rem;
    logic [4:0]  r_body_off, n_body_off;
    logic [15:0] r_format_tag, n_format_tag;
    logic [15:0] r_channels, n_channels;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_depth, n_depth;
    logic        r_fmt_captured, n_fmt_captured;
    logic        r_data_started, n_data_started;
    logic [7:0]  r_prev_byte, n_prev_byte;
    logic [1:0]  r_sample_idx, n_sample_idx;
    logic [CH_W-1:0] r_cur_chan, n_cur_chan;
    t_status     r_error, n_error;

    logic [7:0]  b;
    logic        bad_magic;
    logic [31:0] new_size;
    logic [1:0]  bps;
    logic        sample_done;
    logic [CH_W:0] chan_inc;
    t_status     val_status;
    t_status     rep_status;
    t_out_word   sample_word;
    t_out_word   report_word;
    logic [1:0]  chan_sat;

    assign b        = i_word.byte_value;
    assign new_size = {b, r_chunk_size[31:8]};
    assign bps      = r_depth[4:3];
    assign chan_inc = {1'b0, r_cur_chan} + (CH_W+1)'(1);

    always_comb begin
        if (!r_fmt_captured) begin
            val_status = ST_NO_FMT;
        end else if (r_channels == 16'd0 || r_channels > 16'(MAX_CHANNELS)
                     || r_rate == 32'd0) begin
            val_status = ST_BAD_CHAN;
        end else if (r_format_tag != FMT_PCM && r_format_tag != FMT_EXTENSIBLE) begin
            val_status = ST_BAD_FORMAT;
        end else if (r_depth != 16'd8 && r_depth != 16'd16 && r_depth != 16'd24) begin
            val_status = ST_BAD_DEPTH;
        end else begin
            val_status = ST_OK;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_pos          = (r_pos == HEADER_LEN) ? r_pos : r_pos + 4'd1;
        n_hdr_cnt      = r_hdr_cnt;
        n_chunk_id     = r_chunk_id;
        n_chunk_size   = r_chunk_size;
        n_body_rem     = r_body_rem;
        n_body_off     = r_body_off;
        n_format_tag   = r_format_tag;
        n_channels     = r_channels;
        n_rate         = r_rate;
        n_depth        = r_depth;
        n_fmt_captured = r_fmt_captured;
        n_data_started = r_data_started;
        n_prev_byte    = r_prev_byte;
        n_sample_idx   = r_sample_idx;
        n_cur_chan     = r_cur_chan;
        n_error        = r_error;
        sample_done    = 1'b0;
        bad_magic      = 1'b0;

        case (r_phase)
            PH_HEADER: begin
                if (r_pos < 4'd4) begin
                    bad_magic = (b != RIFF_MAGIC[{r_pos[1:0], 3'b000} +: 8]);
                end else if (r_pos >= 4'd8) begin
                    bad_magic = (b != WAVE_MAGIC[{r_pos[1:0], 3'b000} +: 8]);
                end
                if (bad_magic) begin
                    n_error = ST_BAD_MAGIC;
                    n_phase = PH_HALT;
                end else if (r_pos == 4'd11) begin
                    n_phase   = PH_CHUNK_HDR;
                    n_hdr_cnt = 3'd0;
                end
            end
            PH_CHUNK_HDR: begin
                if (!r_hdr_cnt[2]) begin
                    n_chunk_id = {b, r_chunk_id[31:8]};
                end else begin
                    n_chunk_size = new_size;
                end
                n_hdr_cnt = r_hdr_cnt + 3'd1;
                if (r_hdr_cnt == 3'd7) begin
                    n_body_rem = new_size;
                    n_body_off = 5'd0;
                    n_phase    = PH_BODY;
                    if (r_chunk_id == ID_DATA && !r_data_started) begin
                        n_data_started = 1'b1;
                        n_error        = val_status;
                        if (val_status == ST_OK) begin
                            n_phase      = PH_DATA;
                            n_sample_idx = 2'd0;
                            n_cur_chan   = '0;
                            n_prev_byte  = 8'd0;
                        end
                    end
                    if (new_size == 32'd0) begin
                        n_phase   = PH_CHUNK_HDR;
                        n_hdr_cnt = 3'd0;
                    end
                end
            end
            PH_BODY: begin
                if (r_chunk_id == ID_FMT && (|r_chunk_size[31:4]) && !r_data_started) begin
                    case (r_body_off)
                        5'd0:  n_format_tag[7:0]  = b;
                        5'd1:  n_format_tag[15:8] = b;
                        5'd2:  n_channels[7:0]    = b;
                        5'd3:  n_channels[15:8]   = b;
                        5'd4:  n_rate[7:0]        = b;
                        5'd5:  n_rate[15:8]       = b;
                        5'd6:  n_rate[23:16]      = b;
                        5'd7:  n_rate[31:24]      = b;
                        5'd14: n_depth[7:0]       = b;
                        5'd15: begin
                            n_depth[15:8]  = b;
                            n_fmt_captured = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                n_body_off = r_body_off[4] ? r_body_off : r_body_off + 5'd1;
                n_body_rem = r_body_rem - 32'd1;
                if (r_body_rem == 32'd1) begin
                    n_phase   = r_chunk_size[0] ? PH_PAD : PH_CHUNK_HDR;
                    n_hdr_cnt = 3'd0;
                end
            end
            PH_DATA: begin
                n_prev_byte = b;
                if ({1'b0, r_sample_idx} + 3'd1 >= {1'b0, bps}) begin
                    sample_done  = 1'b1;
                    n_sample_idx = 2'd0;
                    n_cur_chan   = (16'(chan_inc) >= r_channels) ? '0 : chan_inc[CH_W-1:0];
                end else begin
                    n_sample_idx = r_sample_idx + 2'd1;
                end
                n_body_rem = r_body_rem - 32'd1;
                if (r_body_rem == 32'd1) begin
                    n_phase   = r_chunk_size[0] ? PH_PAD : PH_CHUNK_HDR;
                    n_hdr_cnt = 3'd0;
                end
            end
            PH_PAD: begin
                n_phase   = PH_CHUNK_HDR;
                n_hdr_cnt = 3'd0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (n_pos < HEADER_LEN) begin
            rep_status = ST_SHORT;
        end else if (n_error != ST_OK) begin
            rep_status = n_error;
        end else if (!n_data_started) begin
            rep_status = ST_NO_DATA;
        end else begin
            rep_status = ST_OK;
        end
    end

    assign chan_sat = (|n_channels[15:2]) ? 2'd3 : n_channels[1:0];

    always_comb begin
        sample_word.kind          = KIND_SAMPLE;
        sample_word.sample        = (bps == 2'd1) ? {b ^ PCM8_BIAS, 8'h00} : {b, r_prev_byte};
        sample_word.channel_index = r_cur_chan[0];
        sample_word.channel_count = chan_sat;
        sample_word.sample_rate   = n_rate;
        sample_word.bit_depth     = n_depth;
        sample_word.status        = ST_OK;
        sample_word.last          = 1'b0;

        report_word.kind          = KIND_REPORT;
        report_word.sample        = 16'sd0;
        report_word.channel_index = 1'b0;
        report_word.channel_count = chan_sat;
        report_word.sample_rate   = n_rate;
        report_word.bit_depth     = n_depth;
        report_word.status        = rep_status;
        report_word.last          = 1'b1;

        o_push.count  = i_step ? ({1'b0, sample_done} + {1'b0, i_word.end_of_file}) : 2'd0;
        o_push.first  = sample_done ? sample_word : report_word;
        o_push.second = report_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.end_of_file)) begin
            r_phase        <= PH_HEADER;
            r_pos          <= 4'd0;
            r_hdr_cnt      <= 3'd0;
            r_chunk_id     <= 32'd0;
            r_chunk_size   <= 32'd0;
            r_body_rem     <= 32'd0;
            r_body_off     <= 5'd0;
            r_format_tag   <= 16'd0;
            r_channels     <= 16'd0;
            r_rate         <= 32'd0;
            r_depth        <= 16'd0;
            r_fmt_captured <= 1'b0;
            r_data_started <= 1'b0;
            r_prev_byte    <= 8'd0;
            r_sample_idx   <= 2'd0;
            r_cur_chan     <= '0;
            r_error        <= ST_OK;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_hdr_cnt      <= n_hdr_cnt;
            r_chunk_id     <= n_chunk_id;
            r_chunk_size   <= n_chunk_size;
            r_body_rem     <= n_body_rem;
            r_body_off     <= n_body_off;
            r_format_tag   <= n_format_tag;
            r_channels     <= n_channels;
            r_rate         <= n_rate;
            r_depth        <= n_depth;
            r_fmt_captured <= n_fmt_captured;
            r_data_started <= n_data_started;
            r_prev_byte    <= n_prev_byte;
            r_sample_idx   <= n_sample_idx;
            r_cur_chan     <= n_cur_chan;
            r_error        <= n_error;
        end
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |->
            (o_push.first.kind == KIND_SAMPLE && o_push.second.kind == KIND_REPORT))
        else $error("two results in one step must be a sample then a report");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_word.end_of_file) |=> (r_phase == PH_HEADER && r_pos == 4'd0))
        else $error("parser did not return to the header phase after the last byte");

endmodule

>>> rtl/core/wsd_out_queue.sv
// ----------------------------------------------------------------------------
// WAV stream decoder result queue
// Four-word result queue that takes up to two words per cycle and drives
// the output channel.
// ----------------------------------------------------------------------------
module wsd_out_queue import wsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_room,
    wsd_out_if.source o_out
);

    t_out_word         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_count, n_count;
    logic              pop;

    assign pop         = o_out.valid && o_out.ready;
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_mem[r_rd];
    assign o_room      = (r_count <= (QPTR_W+1)'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + QPTR_W'(i_push.count);
        n_rd    = r_rd + QPTR_W'(pop);
        n_count = r_count + (QPTR_W+1)'(i_push.count) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("result queue holds more words than its depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("words pushed while the result queue lacked room for two");

endmodule

>>> rtl/core/wav_stream_pcm_decoder.sv
// ----------------------------------------------------------------------------
// WAV stream PCM decoder
// Takes a WAV file one byte per word, walks its RIFF chunks and emits signed
// 16-bit samples followed by an end report carrying the file status.
// ----------------------------------------------------------------------------
// The decoder accepts one file byte per clock while the result queue has room.
// A byte is held in an input register, parsed, and its results (at most a
// sample and, on the final byte, an end report) enter a four-word result
// queue, which drives the output. A new byte is taken whenever the
// input register is empty or the queue holds two words or fewer, which leaves
// room for the two words that the held byte can produce; with the output side
// ready the sustained rate is one byte per cycle. The end report returns the
// decoder to its reset state, so the next byte starts a new file.
module wav_stream_pcm_decoder import wsd_pkg::*; #(
    parameter int MAX_CHANNELS = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsd_in_if.sink    i_in,
    wsd_out_if.source o_out
);

    logic     r_in_valid;
    t_in_word r_in_word;
    logic     room;
    logic     step;
    t_push    push;

    assign step       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.data;
        end
    end

    wsd_parser #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in_word),
        .o_push  (push)
    );

    wsd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !room) |=> (r_in_valid && $stable(r_in_word)))
        else $error("held input byte lost while the result queue was full");

endmodule
